// File: src/rcw_pkg.sv
// Package for the raycast wall column span: constants, word types and the cosine table.
package rcw_pkg;

  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned TILE          = 64;
  localparam int unsigned COS_ENTRIES   = 1024;

  localparam int unsigned COS_W   = $clog2(COS_ENTRIES);
  localparam int unsigned COS_QTR = COS_ENTRIES / 4;
  localparam int unsigned QIDX_W  = COS_W - 1;       // holds 0 .. COS_QTR
  localparam int unsigned TILE_W  = $clog2(TILE);

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_PLAYER_ANGLE = 2'd0,
    CFG_PROJ_DIST    = 2'd1,
    CFG_TEX_HEIGHT   = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  column;
    logic [19:0] ray_distance;
    logic [11:0] ray_angle;
    logic [15:0] hit_x;
    logic [15:0] hit_y;
    logic        hit_vertical;
    logic [3:0]  hit_content;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [8:0]  wall_top;
    logic [8:0]  wall_bottom;
    logic [15:0] strip_height;
    logic [2:0]  tex_index;
    logic [5:0]  tex_column;
    logic [24:0] tex_step;
    logic        darken;
  } out_word_t;

  // quarter wave, entry j = cos(j/COS_QTR * pi/2) in Q16
  typedef logic [16:0] cos_tab_t [0:COS_QTR];

  function automatic cos_tab_t cos_tab_build();
    cos_tab_t        t;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int j = 0; j <= int'(COS_QTR); j++) begin
      u    = longint'(j) * (Q30_ONE / COS_QTR);
      x    = (u * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      // Taylor terms, divisor (2n-1)(2n) for n = 1 .. 8
      term = ((term * x2) >> 30) / 2;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 12;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 30;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 56;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 90;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 132;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 182;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 240;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      t[j] = 17'((sum + 8192) >>> 14);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = cos_tab_build();

endpackage

// File: src/raycast_wall_column_span.sv
// Raycast wall column span: pipelined fish-eye correction, projection and texture step.
// Usage: one ray hit word per column enters on in_valid_i/in_ready_o; one result word
// leaves on out_valid_o/out_ready_i for each, in order.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 player angle, 1 projection plane
// distance, 2 texture height) and cfg_data_i; always ready. Write only when idle.
// Pipeline: 45 register stages - cosine lookup, distance multiply, height overflow check,
// 16 restoring divide stages for the strip height, span clamp, then 25 restoring divide
// stages for the texture step. One bit of quotient per stage sets the depth.
// Throughput: one word per cycle while the output is not stalled.
// Stall: each stage holds while the one after it is full and stalled; empty stages
// still fill, so bubbles close up and input is taken until every stage is occupied.
// Reset: all stage valid bits clear, registers return to angle 0, distance 277,
// texture height 64.
module raycast_wall_column_span (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcw_pkg::in_word_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rcw_pkg::out_word_t out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i
);
  import rcw_pkg::*;

  localparam int unsigned QB    = 16;               // strip height quotient bits
  localparam int unsigned SB    = 25;               // texture step quotient bits
  localparam int unsigned PW    = 37;               // perpendicular distance width
  localparam int unsigned NUMW  = TILE_W + 12 + 24;
  localparam int unsigned ST_A  = 0;
  localparam int unsigned ST_B  = 1;
  localparam int unsigned ST_C  = 2;
  localparam int unsigned ST_D0 = 3;
  localparam int unsigned ST_E  = ST_D0 + QB;
  localparam int unsigned ST_F0 = ST_E + 1;
  localparam int unsigned NST   = ST_F0 + SB;
  localparam logic [16:0] HALF_SCR = 17'(SCREEN_HEIGHT / 2);
  localparam logic [16:0] SCR_H    = 17'(SCREEN_HEIGHT);
  localparam logic [SB-1:0] STEP_MAX = 25'h1000000;

  typedef struct packed {
    logic [9:0]    column;
    logic [2:0]    tex_index;
    logic [5:0]    tex_column;
    logic          darken;
    logic [19:0]   rdist;
    logic [16:0]   cosv;
    logic          cpos;
    logic [PW-1:0] perp;
    logic          sat;
    logic [PW-1:0] rem;
    logic [QB-1:0] hq;
    logic [15:0]   height;
    logic [8:0]    top;
    logic [8:0]    bottom;
    logic          hz;
    logic [15:0]   srem;
    logic [SB-1:0] sq;
  } stage_t;

  logic [11:0] player_angle_q;
  logic [11:0] proj_dist_q;
  logic [8:0]  tex_height_q;

  logic   [NST-1:0] vld_q;
  logic   [NST-1:0] rdy;
  stage_t           pl_q [0:NST-1];
  stage_t           pl_d [0:NST-1];

  logic [NUMW-1:0] num;
  logic [SB-1:0]   snum;

  assign cfg_ready_o = 1'b1;
  assign num  = {{TILE_W'(0), proj_dist_q} << TILE_W, 24'b0};
  assign snum = {tex_height_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_angle_q <= '0;
      proj_dist_q    <= 12'd277;
      tex_height_q   <= 9'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PLAYER_ANGLE: player_angle_q <= cfg_data_i;
        CFG_PROJ_DIST:    proj_dist_q    <= cfg_data_i;
        CFG_TEX_HEIGHT:   tex_height_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    logic [11:0]     delta;
    logic [COS_W-1:0] k;
    logic [QIDX_W-1:0] r;
    logic [15:0]     coord;
    logic [15:0]     cmask;
    logic [PW:0]     rsh;
    logic [16:0]     ssh;
    logic [NUMW-17:0] numhi;
    logic [14:0]     half;
    logic [16:0]     sum;
    logic [15:0]     h;
    int unsigned     b;

    // stage A: angle difference and cosine lookup
    delta = in_i.ray_angle - player_angle_q;
    k     = COS_W'(delta >> (12 - COS_W));
    r     = QIDX_W'(k[COS_W-3:0]);
    pl_d[ST_A] = pl_q[ST_A];
    pl_d[ST_A].column    = in_i.column;
    pl_d[ST_A].tex_index = 3'(in_i.hit_content - 4'd1);
    coord = in_i.hit_vertical ? in_i.hit_y : in_i.hit_x;
    cmask = coord & 16'(TILE - 1);
    pl_d[ST_A].tex_column = cmask[5:0];
    pl_d[ST_A].darken     = in_i.hit_vertical;
    pl_d[ST_A].rdist      = in_i.ray_distance;
    if (k[COS_W-1:COS_W-2] == 2'd0) begin
      pl_d[ST_A].cosv = COS_TAB[r];
      pl_d[ST_A].cpos = COS_TAB[r] != '0;
    end else if (k[COS_W-1:COS_W-2] == 2'd3) begin
      pl_d[ST_A].cosv = COS_TAB[QIDX_W'(COS_QTR) - r];
      pl_d[ST_A].cpos = COS_TAB[QIDX_W'(COS_QTR) - r] != '0;
    end else begin
      pl_d[ST_A].cosv = '0;
      pl_d[ST_A].cpos = 1'b0;
    end

    numhi = num[NUMW-1:16];
    for (int i = 1; i < int'(NST); i++) begin
      pl_d[i] = pl_q[i-1];
      if (i == ST_B) begin
        pl_d[i].perp = PW'(pl_q[i-1].rdist) * PW'(pl_q[i-1].cosv);
        pl_d[i].sat  = (pl_q[i-1].rdist == '0) || !pl_q[i-1].cpos;
      end else if (i == ST_C) begin
        // quotient would not fit in 16 bits
        if (PW'(numhi) >= pl_q[i-1].perp) pl_d[i].sat = 1'b1;
        pl_d[i].rem = PW'(numhi);
        pl_d[i].hq  = '0;
      end else if (i >= ST_D0 && i < ST_E) begin
        b   = QB - 1 - (i - ST_D0);
        rsh = {pl_q[i-1].rem, num[b]};
        if (rsh >= {1'b0, pl_q[i-1].perp}) begin
          rsh = rsh - {1'b0, pl_q[i-1].perp};
          pl_d[i].hq[b] = 1'b1;
        end
        pl_d[i].rem = rsh[PW-1:0];
      end else if (i == ST_E) begin
        h = pl_q[i-1].sat ? 16'hFFFF : pl_q[i-1].hq;
        pl_d[i].height = h;
        pl_d[i].hz     = h == '0;
        half = h[15:1];
        if (17'(half) >= HALF_SCR) pl_d[i].top = '0;
        else                       pl_d[i].top = 9'(HALF_SCR - 17'(half));
        sum = HALF_SCR + 17'(half);
        if (sum > SCR_H) pl_d[i].bottom = 9'(SCR_H);
        else             pl_d[i].bottom = sum[8:0];
        pl_d[i].srem = '0;
        pl_d[i].sq   = '0;
      end else begin
        b   = SB - 1 - (i - ST_F0);
        ssh = {pl_q[i-1].srem, snum[b]};
        if (ssh >= {1'b0, pl_q[i-1].height}) begin
          ssh = ssh - {1'b0, pl_q[i-1].height};
          pl_d[i].sq[b] = 1'b1;
        end
        pl_d[i].srem = ssh[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < int'(NST); i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) pl_q[0] <= pl_d[0];
    for (int i = 1; i < int'(NST); i++) begin
      if (rdy[i] && vld_q[i-1]) pl_q[i] <= pl_d[i];
    end
  end

  assign out_valid_o        = vld_q[NST-1];
  assign out_o.out_column   = pl_q[NST-1].column;
  assign out_o.wall_top     = pl_q[NST-1].top;
  assign out_o.wall_bottom  = pl_q[NST-1].bottom;
  assign out_o.strip_height = pl_q[NST-1].height;
  assign out_o.tex_index    = pl_q[NST-1].tex_index;
  assign out_o.tex_column   = pl_q[NST-1].tex_column;
  // tall textures can push the step past 1.0 in Q9.16 terms of 256 rows
  assign out_o.tex_step     = (pl_q[NST-1].hz || pl_q[NST-1].sq > STEP_MAX) ? STEP_MAX
                                                                          : pl_q[NST-1].sq;
  assign out_o.darken       = pl_q[NST-1].darken;

  a_zero_height_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.strip_height == '0 |-> out_o.tex_step == 25'h1000000)
    else $error("zero strip height without saturated step");

  a_span_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.wall_top <= out_o.wall_bottom)
    else $error("wall top below wall bottom");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word not captured");

  a_sat_height : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_E] && pl_q[ST_E].height == 16'hFFFF |-> pl_q[ST_E].top == '0)
    else $error("saturated height must clamp top to zero");

endmodule

// File: bench/raycast_wall_column_span_tb.sv
// Self-checking bench for the raycast wall column span: predicted versus observed words.
`timescale 1ns / 1ps

module raycast_wall_column_span_tb;
  import rcw_pkg::*;

  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 60;   // a little beyond the 45 stage pipeline
  localparam int unsigned LONG_HOLD  = 300;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HPI_Q30 = 64'd1686629713;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_e  cfg_index = CFG_PLAYER_ANGLE;
  logic [11:0] cfg_data = '0;

  // bench copy of the registers
  logic [11:0] view_angle;
  logic [11:0] plane_dist;
  logic [8:0]  texel_rows;

  out_word_t   expected_spans[$];
  int          n_errors = 0;
  int          n_columns = 0;
  int          n_checked = 0;
  int          idle_cycles = 0;
  bit          send_gaps = 1'b0;
  bit          recv_stalls = 1'b0;
  bit          long_hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  raycast_wall_column_span DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // cos(u * pi/2), u in Q30 quarter turns, Q16 result
  function automatic longint quarter_cos(longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (u * HPI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return (acc + 8192) >>> 14;
  endfunction

  function automatic longint cos_entry(longint unsigned k);
    longint unsigned frac;
    longint unsigned rem;
    frac = ((k % COS_ENTRIES) << 32) / COS_ENTRIES;
    rem  = frac & (ONE_Q30 - 1);
    case ((frac >> 30) & 3)
      0: return quarter_cos(rem);
      1: return -quarter_cos(ONE_Q30 - rem);
      2: return -quarter_cos(rem);
      default: return quarter_cos(ONE_Q30 - rem);
    endcase
  endfunction

  function automatic out_word_t project_column(in_word_t hit);
    out_word_t       o;
    logic [11:0]     delta;
    longint          c;
    longint unsigned h;
    longint unsigned stp;
    longint          top;
    longint          bot;
    delta = hit.ray_angle - view_angle;
    c = cos_entry((longint'(delta) * COS_ENTRIES) >> 12);
    if (hit.ray_distance == 0 || c <= 0) begin
      h = 65535;
    end else begin
      h = ((longint'(TILE) * plane_dist) << 24) / (longint'(hit.ray_distance) * c);
      if (h > 65535) h = 65535;
    end
    top = longint'(SCREEN_HEIGHT / 2) - longint'(h / 2);
    bot = longint'(SCREEN_HEIGHT / 2) + longint'(h / 2);
    if (top < 0) top = 0;
    if (bot > longint'(SCREEN_HEIGHT)) bot = SCREEN_HEIGHT;
    if (h == 0) begin
      stp = 64'd16777216;
    end else begin
      stp = (longint'(texel_rows) << 16) / h;
      if (stp > 64'd16777216) stp = 64'd16777216;
    end
    o.out_column   = hit.column;
    o.wall_top     = top[8:0];
    o.wall_bottom  = bot[8:0];
    o.strip_height = h[15:0];
    o.tex_index    = 3'(hit.hit_content - 4'd1);
    o.tex_column   = 6'((hit.hit_vertical ? hit.hit_y : hit.hit_x) % TILE);
    o.tex_step     = stp[24:0];
    o.darken       = hit.hit_vertical;
    return o;
  endfunction

  // prediction, register tracking, checking and watchdog, all on the sampled edge
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLAYER_ANGLE: view_angle = cfg_data;
          CFG_PROJ_DIST:    plane_dist = cfg_data;
          CFG_TEX_HEIGHT:   texel_rows = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_spans.push_back(project_column(in_word));
        n_columns++;
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (expected_spans.size() == 0) begin
          $error("unexpected result word: %p", out_word);
          n_errors++;
        end else begin
          want = expected_spans.pop_front();
          if (out_word.out_column !== want.out_column) begin
            $error("out_column exp %0d got %0d", want.out_column, out_word.out_column);
            n_errors++;
          end
          if (out_word.wall_top !== want.wall_top) begin
            $error("wall_top exp %0d got %0d", want.wall_top, out_word.wall_top);
            n_errors++;
          end
          if (out_word.wall_bottom !== want.wall_bottom) begin
            $error("wall_bottom exp %0d got %0d", want.wall_bottom, out_word.wall_bottom);
            n_errors++;
          end
          if (out_word.strip_height !== want.strip_height) begin
            $error("strip_height exp %0d got %0d", want.strip_height,
                   out_word.strip_height);
            n_errors++;
          end
          if (out_word.tex_index !== want.tex_index) begin
            $error("tex_index exp %0d got %0d", want.tex_index, out_word.tex_index);
            n_errors++;
          end
          if (out_word.tex_column !== want.tex_column) begin
            $error("tex_column exp %0d got %0d", want.tex_column, out_word.tex_column);
            n_errors++;
          end
          if (out_word.tex_step !== want.tex_step) begin
            $error("tex_step exp %0d got %0d", want.tex_step, out_word.tex_step);
            n_errors++;
          end
          if (out_word.darken !== want.darken) begin
            $error("darken exp %0d got %0d", want.darken, out_word.darken);
            n_errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: random stalls per word, plus one long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      n = recv_stalls ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid && !long_hold_req);
    end
  end

  task automatic send_ray(in_word_t w);
    int gap;
    gap = send_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_view(logic [11:0] ang, logic [11:0] pd, logic [11:0] th);
    write_reg(CFG_PLAYER_ANGLE, ang);
    write_reg(CFG_PROJ_DIST, pd);
    write_reg(CFG_TEX_HEIGHT, th);
  endtask

  function automatic in_word_t random_ray();
    in_word_t w;
    w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0:       w.ray_distance = 20'($urandom_range(0, 255));
      1, 2, 3: w.ray_distance = 20'($urandom_range(256, 16383));
      4, 5, 6: w.ray_distance = 20'($urandom_range(16384, 262143));
      default: ;
    endcase
    // mostly rays inside the field of view
    if ($urandom_range(0, 3) != 0)
      w.ray_angle = view_angle + 12'($urandom_range(0, 1400)) - 12'd700;
    return w;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_ray(random_ray());
  endtask

  task automatic test_directed();
    in_word_t w;
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    for (int i = 0; i < 16; i++) begin
      w = '0;
      w.column       = (i % 2) ? 10'h3FF : 10'(i);
      w.ray_angle    = 12'd0;
      w.hit_content  = 4'(i);
      w.hit_vertical = i[0];
      w.hit_x        = (i % 3 == 0) ? 16'hFFFF : 16'(i * 37);
      w.hit_y        = (i % 3 == 1) ? 16'hFFFF : 16'(i * 53);
      case (i)
        0:  w.ray_distance = 20'd0;                        // zero distance
        1:  w.ray_distance = 20'hFFFFF;                    // farthest, tiny strip
        2:  w.ray_distance = 20'd1;                        // height saturates
        3:  begin w.ray_distance = 20'd2560; w.ray_angle = 12'd1024; end // right angle
        4:  begin w.ray_distance = 20'd2560; w.ray_angle = 12'd2048; end // behind
        5:  begin w.ray_distance = 20'd2560; w.ray_angle = 12'd3072; end
        6:  begin w.ray_distance = 20'd2560; w.ray_angle = 12'd1023; end // just inside
        7:  begin w.ray_distance = 20'd2560; w.ray_angle = 12'hFFF; end
        8:  w.ray_distance = 20'd17728;                    // strip of 256 rows
        9:  w.ray_distance = 20'd20000;
        default: w.ray_distance = 20'($urandom_range(1, 20'hFFFFF));
      endcase
      send_ray(w);
    end
    drain_results();
  endtask

  task automatic test_config_sweep();
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    set_view(12'd4095, 12'd4095, 12'd256);
    run_random(60);
    drain_results();
    set_view(12'd1, 12'd1, 12'd1);
    run_random(60);
    drain_results();
    set_view(12'd2048, 12'd100, 12'd128);
    run_random(60);
    drain_results();
    set_view(12'd0, 12'd277, 12'd64);
  endtask

  task automatic test_random_stream();
    for (int blk = 0; blk < 8; blk++) begin
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      if (blk % 4 == 3) begin
        drain_results();
        set_view(12'($urandom), 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 256)));
      end
      run_random(50);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    long_hold_req = 1'b1;
    run_random(120);
    // sender pauses until every word is back
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_spans.size() != 0) @(posedge clk_i);
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    run_random(40);
    drain_results();
  endtask

  initial begin
    view_angle = 12'd0;
    plane_dist = 12'd277;
    texel_rows = 9'd64;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random_stream();
    test_backpressure();
    $display("covered %0d columns, %0d words checked: edge distances and angles,",
             n_columns, n_checked);
    $display("register extremes, random stalls and a full-pipe back-pressure hold");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
